// ----- sv/scws_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the scaled channel window statistics block
// no dependencies

package scws_pkg;

  localparam int unsigned VAL_W    = 32;
  localparam int unsigned SD_W     = 31;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned ROOT_W   = 31;
  localparam int unsigned RAD_W    = 62;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned SQCNT_W  = 5;
  localparam logic [SD_W-1:0] SD_MAX = 31'h7fffffff;

  typedef enum logic [2:0] {
    REG_RAW_MIN       = 3'd0,
    REG_RAW_MAX       = 3'd1,
    REG_VALUE_MIN     = 3'd2,
    REG_VALUE_MAX     = 3'd3,
    REG_RANGE_LOW     = 3'd4,
    REG_RANGE_HIGH    = 3'd5,
    REG_RANGE_CHECK   = 3'd6,
    REG_WINDOW_LENGTH = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    DIV_SCALE = 2'd0,
    DIV_MEAN  = 2'd1,
    DIV_VAR   = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_min;
    logic signed [VAL_W-1:0] value_max;
    logic signed [VAL_W-1:0] range_low;
    logic signed [VAL_W-1:0] range_high;
    logic                    check_on;
    logic [CNT_W-1:0]        window_length;
  } cfg_t;

  typedef struct packed {
    logic     load;
    logic     mul;
    logic     clear;
    logic     store;
    logic     scan_init;
    logic     sum_acc;
    logic     sq_e;
    logic     sq_p0;
    logic     sq_p1;
    logic     sq_p2;
    logic     sq_p3;
    logic     div_start;
    div_sel_e div_sel;
    logic     sqrt_step;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic zero_span;
    logic stats_go;
    logic last;
    logic div_done;
    logic sqrt_last;
  } st_t;

endpackage

// ----- sv/scws_in_if.sv -----
`timescale 1ns / 1ps
// input channel: one raw sample or a window clear per item
// no dependencies

interface scws_in_if #(
  parameter int unsigned RAW_BITS = 16
);
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic signed [RAW_BITS-1:0] raw_sample;

  modport source (output valid, output kind, output raw_sample, input ready);
  modport sink   (input valid, input kind, input raw_sample, output ready);
endinterface

// ----- sv/scws_out_if.sv -----
`timescale 1ns / 1ps
// output channel: scaled value, range flags and window statistics per item
// no dependencies

interface scws_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] scaled_value;
  logic               in_range;
  logic               range_changed;
  logic signed [31:0] mean_value;
  logic [30:0]        std_dev;
  logic [6:0]         window_count;
  logic               stats_valid;

  modport source (output valid, output scaled_value, output in_range, output range_changed,
                  output mean_value, output std_dev, output window_count,
                  output stats_valid, input ready);
  modport sink   (input valid, input scaled_value, input in_range, input range_changed,
                  input mean_value, input std_dev, input window_count,
                  input stats_valid, output ready);
endinterface

// ----- sv/scws_div.sv -----
`timescale 1ns / 1ps
// serial restoring divider, one quotient bit per cycle
// no dependencies

module scws_div #(
  parameter int unsigned DIVIDEND_W = 64,
  parameter int unsigned DIVISOR_W  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);
  localparam int unsigned CW = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CW-1:0]         cnt_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DIVIDEND_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

// ----- sv/scws_ctrl.sv -----
`timescale 1ns / 1ps
// sequencer for scaling, window scans, division and square root
// depends on scws_pkg

module scws_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  input  scws_pkg::st_t st_i,
  output scws_pkg::cmd_t cmd_o
);
  import scws_pkg::*;

  typedef enum logic [20:0] {
    S_IDLE    = 21'h000001,
    S_MUL     = 21'h000002,
    S_SDIV_GO = 21'h000004,
    S_SDIV_W  = 21'h000008,
    S_STORE   = 21'h000010,
    S_CHECK   = 21'h000020,
    S_SUM_A   = 21'h000040,
    S_SUM_B   = 21'h000080,
    S_MDIV_GO = 21'h000100,
    S_MDIV_W  = 21'h000200,
    S_SQ_A    = 21'h000400,
    S_SQ_E    = 21'h000800,
    S_SQ_P0   = 21'h001000,
    S_SQ_P1   = 21'h002000,
    S_SQ_P2   = 21'h004000,
    S_SQ_P3   = 21'h008000,
    S_VDIV_GO = 21'h010000,
    S_VDIV_W  = 21'h020000,
    S_SQRT    = 21'h040000,
    S_CLEAR   = 21'h080000,
    S_DONE    = 21'h100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.div_sel = DIV_SCALE;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        if (st_i.is_clear)       state_d = S_CLEAR;
        else if (st_i.zero_span) state_d = S_STORE;
        else                     state_d = S_SDIV_GO;
      end
      S_SDIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d = S_SDIV_W;
      end
      S_SDIV_W: begin
        if (st_i.div_done) state_d = S_STORE;
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.scan_init = 1'b1;
        state_d = st_i.stats_go ? S_SUM_A : S_DONE;
      end
      S_SUM_A: state_d = S_SUM_B;
      S_SUM_B: begin
        cmd_o.sum_acc = 1'b1;
        state_d = st_i.last ? S_MDIV_GO : S_SUM_A;
      end
      S_MDIV_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_MEAN;
        cmd_o.scan_init = 1'b1;
        state_d = S_MDIV_W;
      end
      S_MDIV_W: begin
        cmd_o.div_sel = DIV_MEAN;
        if (st_i.div_done) state_d = S_SQ_A;
      end
      S_SQ_A: state_d = S_SQ_E;
      S_SQ_E: begin
        cmd_o.sq_e = 1'b1;
        state_d = S_SQ_P0;
      end
      S_SQ_P0: begin
        cmd_o.sq_p0 = 1'b1;
        state_d = S_SQ_P1;
      end
      S_SQ_P1: begin
        cmd_o.sq_p1 = 1'b1;
        state_d = S_SQ_P2;
      end
      S_SQ_P2: begin
        cmd_o.sq_p2 = 1'b1;
        state_d = S_SQ_P3;
      end
      S_SQ_P3: begin
        cmd_o.sq_p3 = 1'b1;
        state_d = st_i.last ? S_VDIV_GO : S_SQ_A;
      end
      S_VDIV_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_VAR;
        state_d = S_VDIV_W;
      end
      S_VDIV_W: begin
        cmd_o.div_sel = DIV_VAR;
        if (st_i.div_done) state_d = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (st_i.sqrt_last) state_d = S_DONE;
      end
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        // result slot frees up when the waiting item is taken
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule

// ----- sv/scws_dp.sv -----
`timescale 1ns / 1ps
// datapath: scaling, range check, sample ring, sums, divider and square root
// depends on scws_pkg and scws_div

module scws_dp #(
  parameter int unsigned WINDOW_MAX = 64,
  parameter int unsigned RAW_BITS   = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  scws_pkg::cmd_t             cmd_i,
  output scws_pkg::st_t              st_o,
  input  scws_pkg::cfg_t             cfg_i,
  input  logic signed [RAW_BITS-1:0] raw_min_i,
  input  logic signed [RAW_BITS-1:0] raw_max_i,
  input  logic                       kind_i,
  input  logic signed [RAW_BITS-1:0] raw_sample_i,
  output logic signed [31:0]         scaled_value_o,
  output logic                       in_range_o,
  output logic                       range_changed_o,
  output logic signed [31:0]         mean_value_o,
  output logic [30:0]                std_dev_o,
  output logic [6:0]                 window_count_o,
  output logic                       stats_valid_o
);
  import scws_pkg::*;

  localparam int unsigned CW  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned PW  = (WINDOW_MAX > 2) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned TW  = VAL_W + CW;
  localparam int unsigned AW  = CW + 33;
  localparam int unsigned H   = (AW + 1) / 2;
  localparam int unsigned SW  = 2 * AW + CW;
  localparam int unsigned PRW = RAW_BITS + 34;
  localparam int unsigned SCW = RAW_BITS + 35;
  localparam int unsigned VSW = RAW_BITS + 35;
  localparam int unsigned DW  = (SW > SCW) ? SW : SCW;
  localparam int unsigned VW  = (3 * CW > RAW_BITS + 2) ? 3 * CW : RAW_BITS + 2;
  localparam logic signed [VSW-1:0] V_HI = {{(VSW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [VSW-1:0] V_LO = {{(VSW-31){1'b1}}, {31{1'b0}}};

  // captured item
  logic                       kind_q;
  logic signed [RAW_BITS-1:0] raw_q;

  // scaling
  logic signed [RAW_BITS:0]   rdiff, span;
  logic signed [32:0]         vdiff;
  logic signed [PRW-1:0]      prod_q;
  logic [PRW-1:0]             prod_abs;
  logic [RAW_BITS:0]          span_abs;
  logic signed [VSW-1:0]      qmag, qs, vfull;
  logic signed [31:0]         v_q;

  // range and window control
  logic                       inr_q, chg_q, prev_q, inr;
  logic [CW-1:0]              fill_q, len, k_q;
  logic [CW:0]                fill_inc;
  logic [PW-1:0]              wp_q, rp_q, rp_prev;
  logic                       stats_on;
  logic signed [31:0]         mem [WINDOW_MAX];
  logic signed [31:0]         rdata_q;

  // statistics
  logic signed [TW-1:0]       total_q;
  logic [TW-1:0]              total_abs;
  logic signed [31:0]         mean_q;
  logic signed [CW+33:0]      e_w;
  logic [AW-1:0]              a_q;
  logic [2*H-1:0]             pp_q;
  logic [SW-1:0]              acc_q;
  logic [2*CW-1:0]            nn_q;
  logic [3*CW-1:0]            d_q;
  logic                       valid_q;

  // divider and square root
  logic                       div_done;
  logic [DW-1:0]              quot, dividend;
  logic [VW-1:0]              divisor;
  logic [RAD_W-1:0]           x_q;
  logic [33:0]                rem_q, rem_n, trial;
  logic [ROOT_W-1:0]          root_q;
  logic [SQCNT_W-1:0]         sq_cnt_q;
  logic                       sat_q;

  assign rdiff    = (RAW_BITS+1)'(raw_q) - (RAW_BITS+1)'(raw_min_i);
  assign span     = (RAW_BITS+1)'(raw_max_i) - (RAW_BITS+1)'(raw_min_i);
  assign vdiff    = 33'(cfg_i.value_max) - 33'(cfg_i.value_min);
  assign prod_abs = prod_q[PRW-1] ? PRW'(-prod_q) : PRW'(prod_q);
  assign span_abs = span[RAW_BITS] ? (RAW_BITS+1)'(-span) : (RAW_BITS+1)'(span);

  assign qmag  = $signed({1'b0, quot[VSW-2:0]});
  assign qs    = (prod_q[PRW-1] ^ span[RAW_BITS]) ? -qmag : qmag;
  assign vfull = VSW'(cfg_i.value_min) + qs;

  assign inr = (v_q >= cfg_i.range_low) && (v_q <= cfg_i.range_high);

  always_comb begin
    if (int'(cfg_i.window_length) > WINDOW_MAX) len = CW'(WINDOW_MAX);
    else                                        len = CW'(cfg_i.window_length);
  end
  assign stats_on = len >= CW'(2);
  assign fill_inc = {1'b0, fill_q} + (CW+1)'(1);
  assign rp_prev  = (rp_q == '0) ? PW'(WINDOW_MAX - 1) : rp_q - PW'(1);

  assign total_abs = total_q[TW-1] ? TW'(-total_q) : TW'(total_q);
  assign e_w = (CW+34)'($signed({1'b0, fill_q})) * (CW+34)'(rdata_q) - (CW+34)'(total_q);

  always_comb begin
    case (cmd_i.div_sel)
      DIV_SCALE: begin
        dividend = DW'({prod_abs, 1'b0}) + DW'(span_abs);
        divisor  = VW'({span_abs, 1'b0});
      end
      DIV_MEAN: begin
        dividend = DW'({total_abs, 1'b0}) + DW'(fill_q);
        divisor  = VW'({fill_q, 1'b0});
      end
      DIV_VAR: begin
        dividend = DW'(acc_q);
        divisor  = VW'(d_q);
      end
      default: begin
        dividend = '0;
        divisor  = '0;
      end
    endcase
  end

  scws_div #(
    .DIVIDEND_W (DW),
    .DIVISOR_W  (VW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign rem_n = {rem_q[31:0], x_q[RAD_W-1:RAD_W-2]};
  assign trial = {1'b0, root_q, 2'b01};

  // window control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      wp_q   <= '0;
      prev_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        fill_q <= '0;
        wp_q   <= '0;
      end else if (cmd_i.store) begin
        if (cfg_i.check_on) prev_q <= inr;
        if (stats_on) begin
          wp_q   <= (wp_q == PW'(WINDOW_MAX - 1)) ? '0 : wp_q + PW'(1);
          fill_q <= (fill_inc > {1'b0, len}) ? len : fill_inc[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && stats_on) mem[wp_q] <= v_q;
    rdata_q <= mem[rp_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      raw_q  <= raw_sample_i;
    end
    if (cmd_i.mul) begin
      prod_q <= rdiff * vdiff;
      if (span == '0) v_q <= cfg_i.value_min;
    end
    if (div_done && cmd_i.div_sel == DIV_SCALE) begin
      if (vfull > V_HI)      v_q <= 32'sh7fffffff;
      else if (vfull < V_LO) v_q <= 32'sh80000000;
      else                   v_q <= 32'(vfull);
    end
    if (cmd_i.clear) begin
      v_q     <= '0;
      inr_q   <= 1'b0;
      chg_q   <= 1'b0;
      valid_q <= 1'b0;
    end
    if (cmd_i.store) begin
      inr_q   <= cfg_i.check_on ? inr : 1'b1;
      chg_q   <= cfg_i.check_on ? (inr != prev_q) : 1'b0;
      valid_q <= 1'b0;
      total_q <= '0;
      acc_q   <= '0;
    end
    if (cmd_i.scan_init) begin
      rp_q <= (wp_q == '0) ? PW'(WINDOW_MAX - 1) : wp_q - PW'(1);
      k_q  <= '0;
    end
    if (cmd_i.sum_acc) begin
      total_q <= total_q + TW'(rdata_q);
      rp_q    <= rp_prev;
      k_q     <= k_q + CW'(1);
    end
    if (div_done && cmd_i.div_sel == DIV_MEAN) begin
      mean_q <= total_q[TW-1] ? -$signed(quot[31:0]) : $signed(quot[31:0]);
    end
    // square of |n*v - total| from half-width partial products
    if (cmd_i.sq_e)  a_q <= e_w[CW+33] ? AW'(-e_w) : AW'(e_w);
    if (cmd_i.sq_p0) pp_q <= a_q[AW-1:H] * a_q[AW-1:H];
    if (cmd_i.sq_p1) begin
      acc_q <= acc_q + (SW'(pp_q) << (2 * H));
      pp_q  <= a_q[H-1:0] * a_q[H-1:0];
    end
    if (cmd_i.sq_p2) begin
      acc_q <= acc_q + SW'(pp_q);
      pp_q  <= a_q[AW-1:H] * a_q[H-1:0];
    end
    if (cmd_i.sq_p3) begin
      acc_q <= acc_q + (SW'(pp_q) << (H + 1));
      rp_q  <= rp_prev;
      k_q   <= k_q + CW'(1);
    end
    nn_q <= fill_q * fill_q;
    d_q  <= nn_q * (fill_q - CW'(1));
    if (div_done && cmd_i.div_sel == DIV_VAR) begin
      sat_q    <= |quot[DW-1:RAD_W];
      x_q      <= quot[RAD_W-1:0];
      root_q   <= '0;
      rem_q    <= '0;
      sq_cnt_q <= '0;
      valid_q  <= 1'b1;
    end
    if (cmd_i.sqrt_step) begin
      x_q      <= {x_q[RAD_W-3:0], 2'b00};
      sq_cnt_q <= sq_cnt_q + SQCNT_W'(1);
      if (rem_n >= trial) begin
        rem_q  <= rem_n - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_n;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd_i.emit) begin
      scaled_value_o  <= v_q;
      in_range_o      <= inr_q;
      range_changed_o <= chg_q;
      mean_value_o    <= valid_q ? mean_q : '0;
      std_dev_o       <= valid_q ? (sat_q ? SD_MAX : root_q) : '0;
      window_count_o  <= CNT_W'(fill_q);
      stats_valid_o   <= valid_q;
    end
  end

  assign st_o.is_clear  = kind_q;
  assign st_o.zero_span = (span == '0);
  assign st_o.stats_go  = stats_on && (fill_q >= CW'(2));
  assign st_o.last      = (k_q == fill_q - CW'(1));
  assign st_o.div_done  = div_done;
  assign st_o.sqrt_last = (sq_cnt_q == SQCNT_W'(ROOT_W - 1));
endmodule

// ----- sv/scaled_channel_window_stats_core.sv -----
`timescale 1ns / 1ps
// top level: configuration registers, sequencer and datapath
// depends on scws_pkg, scws_in_if, scws_out_if, scws_ctrl, scws_dp
//
//   channel  | direction | handshake       | payload
//   in_i     | in        | valid / ready   | kind, raw_sample
//   out_o    | out       | valid / ready   | scaled_value .. stats_valid
//   apb      | in        | psel / penable  | paddr, pwdata, prdata
//
// a sample item uses the shared serial divider for the scaling, mean and
// variance quotients as needed, one quotient bit per cycle on a dividend of
// D = 3*clog2(WINDOW_MAX+1) + 66 bits (87 by default); each held sample gets
// four partial-product steps for its squared term, and the root takes 31 steps.
// reset empties the window; the ring itself is not cleared.
// a new item is taken once the previous one sits in the output register.

module scaled_channel_window_stats_core #(
  parameter int unsigned WINDOW_MAX = 64,
  parameter int unsigned RAW_BITS   = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  scws_in_if.sink                     in_i,
  scws_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scws_pkg::ADDR_W-1:0] paddr,
  input  logic [scws_pkg::DATA_W-1:0] pwdata,
  output logic [scws_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import scws_pkg::*;

  logic signed [RAW_BITS-1:0] raw_min_q, raw_max_q;
  cfg_t                       cfg_q;
  cmd_t                       cmd;
  st_t                        st;
  reg_idx_e                   idx;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_min_q           <= '0;
      raw_max_q           <= RAW_BITS'(1);
      cfg_q.value_min     <= '0;
      cfg_q.value_max     <= 32'sd65536;
      cfg_q.range_low     <= '0;
      cfg_q.range_high    <= '0;
      cfg_q.check_on      <= 1'b0;
      cfg_q.window_length <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        REG_RAW_MIN:       raw_min_q           <= pwdata[RAW_BITS-1:0];
        REG_RAW_MAX:       raw_max_q           <= pwdata[RAW_BITS-1:0];
        REG_VALUE_MIN:     cfg_q.value_min     <= pwdata;
        REG_VALUE_MAX:     cfg_q.value_max     <= pwdata;
        REG_RANGE_LOW:     cfg_q.range_low     <= pwdata;
        REG_RANGE_HIGH:    cfg_q.range_high    <= pwdata;
        REG_RANGE_CHECK:   cfg_q.check_on      <= pwdata[0];
        REG_WINDOW_LENGTH: cfg_q.window_length <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RAW_MIN:       prdata = DATA_W'(raw_min_q);
      REG_RAW_MAX:       prdata = DATA_W'(raw_max_q);
      REG_VALUE_MIN:     prdata = cfg_q.value_min;
      REG_VALUE_MAX:     prdata = cfg_q.value_max;
      REG_RANGE_LOW:     prdata = cfg_q.range_low;
      REG_RANGE_HIGH:    prdata = cfg_q.range_high;
      REG_RANGE_CHECK:   prdata = DATA_W'(cfg_q.check_on);
      REG_WINDOW_LENGTH: prdata = DATA_W'(cfg_q.window_length);
      default:           prdata = '0;
    endcase
  end

  scws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  scws_dp #(
    .WINDOW_MAX (WINDOW_MAX),
    .RAW_BITS   (RAW_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .st_o            (st),
    .cfg_i           (cfg_q),
    .raw_min_i       (raw_min_q),
    .raw_max_i       (raw_max_q),
    .kind_i          (in_i.kind),
    .raw_sample_i    (in_i.raw_sample),
    .scaled_value_o  (out_o.scaled_value),
    .in_range_o      (out_o.in_range),
    .range_changed_o (out_o.range_changed),
    .mean_value_o    (out_o.mean_value),
    .std_dev_o       (out_o.std_dev),
    .window_count_o  (out_o.window_count),
    .stats_valid_o   (out_o.stats_valid)
  );
endmodule
